FILE: hw/rtl/lvpe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lvpe_pkg;

    // Shared divider geometry
    localparam int DIV_NW = 56;   // dividend width
    localparam int DIV_DW = 32;   // divisor width
    localparam int DIV_CW = 6;    // step count width

    // Square-root unit geometry
    localparam int SQ_W  = 56;
    localparam int SQ_RW = 28;

    // Field widths
    localparam int DEPTH_W = 31;
    localparam int VP_W    = 20;
    localparam int RHO_W   = 18;
    localparam int CFG_W   = 6;

    // Density and Poisson ramp constants (scaled by 16 / 10000)
    localparam int RHO_BASE = 29840;
    localparam int RHO_GAIN = 1579;
    localparam int RHO_RND  = 5000;
    localparam int T_OFS    = 32960;
    localparam int T_MAX    = 7040;
    localparam int VS_NUM   = 14080;
    localparam int VS_DEN   = 84480;

    // x / 10000 as (x * RHO_RECIP) >> RHO_SHIFT, exact for x below 2^32
    localparam logic [31:0] RHO_RECIP = 32'hD1B7_1759;
    localparam int          RHO_SHIFT = 45;

    // Quotient bit counts per divide
    localparam int NB_INTERP = 21;
    localparam int NB_VS     = 40;

    typedef struct packed {
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
        logic [DIV_CW-1:0] nbits;
    } t_div_req;

endpackage

`default_nettype wire

FILE: hw/rtl/layered_velocity_profile_eval_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Write: a write transfer takes effect at its accepting edge; busy stays low.
// Query: strobe is registered at the accepting edge for filled, ineligible or negative-depth
// points; else it scans the table entry by entry (read state, then compare state), interpolates
// with a multiply and a divide when needed, then density, the vs divide and the 28-step root.
// Throughput: one query at a time; busy is low in the cycle that carries the strobe.
// Reset (sync, active low) clears control, num_layers = 1, table kept; no receiver stall.
module layered_velocity_profile_eval_unit
    import lvpe_pkg::*;
#(
    parameter int MAX_LAYERS = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic                i_cfg_we,
    input  wire logic [CFG_W-1:0]    i_cfg_wdata,
    input  wire logic                i_command,
    input  wire logic [4:0]          i_layer_index,
    input  wire logic [DEPTH_W-1:0]  i_layer_depth,
    input  wire logic [VP_W-1:0]     i_layer_vp,
    input  wire logic signed [31:0]  i_point_depth,
    input  wire logic signed [31:0]  i_gtl_shift,
    input  wire logic                i_already_filled,
    input  wire logic                i_domain_eligible,
    output logic                     o_strobe,
    output logic [VP_W-1:0]          o_vp_out,
    output logic [RHO_W-1:0]         o_rho_out,
    output logic [VP_W-1:0]          o_vs_out,
    output logic                     o_filled,
    output logic                     o_data_gap
);

    localparam int AW = $clog2(MAX_LAYERS);
    // compare width wide enough for the config value, the layer index and MAX_LAYERS
    localparam int CW = (AW >= 6) ? AW + 1 : 7;
    localparam int EW = DEPTH_W + VP_W;

    typedef enum logic [4:0] {
        S_IDLE, S_RD, S_CK, S_MUL, S_LD1, S_WAIT1, S_RHO, S_RCP,
        S_T, S_MULA, S_LD3, S_WAIT3, S_WAITS
    } t_state;

    t_state r_state;

    logic [CFG_W-1:0]   r_num_layers;
    logic [AW-1:0]      r_idx;
    logic [31:0]        r_d;        // shifted depth, known non-negative
    logic [DEPTH_W-1:0] r_d0, r_d1;
    logic [VP_W-1:0]    r_v0, r_v1;
    logic               r_dir;      // 1: velocity falls across the interval
    logic [DIV_NW-1:0]  r_prod;
    logic [VP_W-1:0]    r_vp;
    logic [RHO_W-1:0]   r_rho;
    logic [15:0]        r_fa;
    logic [16:0]        r_fb;
    t_div_req           r_div_req;
    logic               r_div_start;
    logic               r_sq_start;
    logic [SQ_W-1:0]    r_sq_x;

    logic               r_strobe;
    logic [VP_W-1:0]    r_vp_out;
    logic [RHO_W-1:0]   r_rho_out;
    logic [VP_W-1:0]    r_vs_out;
    logic               r_filled;
    logic               r_gap;

    // ---------------------------------------------------------------
    // Layer table: depth and vp packed into one entry
    // ---------------------------------------------------------------
    logic          accept;
    logic          tbl_we;
    logic          tbl_re;
    logic [EW-1:0] tbl_rdata;
    logic [DEPTH_W-1:0] rd_depth;
    logic [VP_W-1:0]    rd_vp;

    assign accept = start && !busy;
    // writes beyond the table depth are dropped
    assign tbl_we = accept && !i_command
                    && (CW'(i_layer_index) < CW'(MAX_LAYERS));
    assign tbl_re = (r_state == S_RD);
    assign rd_depth = tbl_rdata[EW-1:VP_W];
    assign rd_vp    = tbl_rdata[VP_W-1:0];

    lvpe_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_LAYERS)
    ) u_tbl (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (AW'(i_layer_index)),
        .i_wdata ({i_layer_depth, i_layer_vp}),
        .i_re    (tbl_re),
        .i_raddr (r_idx),
        .o_rdata (tbl_rdata)
    );

    // ---------------------------------------------------------------
    // Shared divider and root unit
    // ---------------------------------------------------------------
    logic              div_done;
    logic [DIV_NW-1:0] div_quot;
    logic              sq_done;
    logic [SQ_RW-1:0]  sq_root;

    lvpe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_req   (r_div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    lvpe_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sq_start),
        .i_x     (r_sq_x),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    // ---------------------------------------------------------------
    // Datapath helpers
    // ---------------------------------------------------------------
    logic [CW-1:0]      n_eff;      // layer count clamped to 1..MAX_LAYERS
    logic [AW-1:0]      last_idx;
    logic signed [32:0] d_sum;
    logic               hit;        // table entry lies deeper than the point
    logic [VP_W-1:0]    dv;
    logic [30:0]        num;
    logic [DEPTH_W-1:0] den;
    logic [VP_W-1:0]    q_vp;
    logic [63:0]        rho_mul;    // density term times the reciprocal of 10000
    logic [RHO_W:0]     t_raw;
    logic [12:0]        t_clip;
    logic [14:0]        t3;

    always_comb begin
        if (r_num_layers == '0) begin
            n_eff = CW'(1);
        end else if (CW'(r_num_layers) > CW'(MAX_LAYERS)) begin
            n_eff = CW'(MAX_LAYERS);
        end else begin
            n_eff = CW'(r_num_layers);
        end
        last_idx = AW'(n_eff - CW'(1));

        d_sum = 33'(i_point_depth) + 33'(i_gtl_shift);
        hit   = {1'b0, rd_depth} > r_d;

        dv  = r_dir ? (r_v0 - r_v1) : (r_v1 - r_v0);
        num = 31'(r_d - {1'b0, r_d0});
        den = r_d1 - r_d0;
        q_vp = div_quot[VP_W-1:0];

        rho_mul = 64'(r_prod[31:0]) * 64'(RHO_RECIP);

        t_raw = {1'b0, r_rho} - (RHO_W + 1)'(T_OFS);
        if (r_rho < RHO_W'(T_OFS)) begin
            t_clip = '0;
        end else if (t_raw > (RHO_W + 1)'(T_MAX)) begin
            t_clip = 13'(T_MAX);
        end else begin
            t_clip = t_raw[12:0];
        end
        t3 = 15'(t_clip) * 15'd3;
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_num_layers <= CFG_W'(1);
            r_div_start  <= 1'b0;
            r_sq_start   <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            r_sq_start  <= 1'b0;
            r_strobe    <= 1'b0;
            if (i_cfg_we) begin
                r_num_layers <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept && i_command) begin
                        r_vp_out  <= '0;
                        r_rho_out <= '0;
                        r_vs_out  <= '0;
                        r_filled  <= 1'b0;
                        r_gap     <= 1'b0;
                        if (i_already_filled) begin
                            r_strobe <= 1'b1;
                        end else if (!i_domain_eligible || d_sum[32]) begin
                            r_gap    <= 1'b1;
                            r_strobe <= 1'b1;
                        end else begin
                            r_d     <= d_sum[31:0];
                            r_idx   <= '0;
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_CK;
                end
                S_CK: begin
                    if (hit) begin
                        if (r_idx == '0) begin
                            r_vp    <= rd_vp;
                            r_state <= S_RHO;
                        end else begin
                            r_d1    <= rd_depth;
                            r_v1    <= rd_vp;
                            r_dir   <= rd_vp < r_v0;
                            r_state <= S_MUL;
                        end
                    end else begin
                        r_d0 <= rd_depth;
                        r_v0 <= rd_vp;
                        if (r_idx == last_idx) begin
                            r_vp    <= rd_vp;
                            r_state <= S_RHO;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_RD;
                        end
                    end
                end
                S_MUL: begin
                    r_prod  <= DIV_NW'(dv) * DIV_NW'(num);
                    r_state <= S_LD1;
                end
                S_LD1: begin
                    // round half away: (2*dv*num + den) / (2*den)
                    r_div_req.num   <= (r_prod << 1) + DIV_NW'(den);
                    r_div_req.den   <= {den, 1'b0};
                    r_div_req.nbits <= DIV_CW'(NB_INTERP);
                    r_div_start     <= 1'b1;
                    r_state         <= S_WAIT1;
                end
                S_WAIT1: begin
                    if (div_done) begin
                        r_vp    <= r_dir ? (r_v0 - q_vp) : (r_v0 + q_vp);
                        r_state <= S_RHO;
                    end
                end
                S_RHO: begin
                    r_prod  <= DIV_NW'(r_vp) * DIV_NW'(RHO_GAIN) + DIV_NW'(RHO_RND);
                    r_state <= S_RCP;
                end
                S_RCP: begin
                    // product stays below 2^31, so the reciprocal gives the exact floor
                    r_rho   <= RHO_W'(RHO_BASE) + rho_mul[RHO_SHIFT +: RHO_W];
                    r_state <= S_T;
                end
                S_T: begin
                    r_fa    <= 16'(VS_NUM) + 16'(t3);
                    r_fb    <= 17'(VS_DEN) + 17'(t3);
                    r_prod  <= DIV_NW'(r_vp) * DIV_NW'(r_vp);
                    r_state <= S_MULA;
                end
                S_MULA: begin
                    r_prod  <= DIV_NW'(r_prod[2*VP_W-1:0]) * DIV_NW'(r_fa);
                    r_state <= S_LD3;
                end
                S_LD3: begin
                    r_div_req.num   <= r_prod;
                    r_div_req.den   <= DIV_DW'(r_fb);
                    r_div_req.nbits <= DIV_CW'(NB_VS);
                    r_div_start     <= 1'b1;
                    r_state         <= S_WAIT3;
                end
                S_WAIT3: begin
                    if (div_done) begin
                        r_sq_x     <= SQ_W'(div_quot);
                        r_sq_start <= 1'b1;
                        r_state    <= S_WAITS;
                    end
                end
                S_WAITS: begin
                    if (sq_done) begin
                        r_vp_out  <= r_vp;
                        r_rho_out <= r_rho;
                        r_vs_out  <= sq_root[VP_W-1:0];
                        r_filled  <= 1'b1;
                        r_gap     <= 1'b0;
                        r_strobe  <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy       = (r_state != S_IDLE);
    assign o_strobe   = r_strobe;
    assign o_vp_out   = r_vp_out;
    assign o_rho_out  = r_rho_out;
    assign o_vs_out   = r_vs_out;
    assign o_filled   = r_filled;
    assign o_data_gap = r_gap;

endmodule

`default_nettype wire

FILE: hw/rtl/lvpe_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lvpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/lvpe_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle. Caller guarantees
// (num >> nbits) < den.
module lvpe_div
    import lvpe_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire t_div_req          i_req,
    output logic                   o_done,
    output logic [DIV_NW-1:0]      o_quot
);

    logic              r_act;
    logic [DIV_CW-1:0] r_cnt;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_NW-1:0] r_sh;
    logic [DIV_NW-1:0] r_q;
    logic              r_done;

    logic [DIV_DW:0]   rem2;
    logic              ge;
    logic [DIV_DW-1:0] n_rem;

    always_comb begin
        rem2  = {r_rem, r_sh[DIV_NW-1]};
        ge    = rem2 >= {1'b0, r_den};
        n_rem = ge ? DIV_DW'(rem2 - {1'b0, r_den}) : rem2[DIV_DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_act <= 1'b1;
                r_cnt <= i_req.nbits;
                r_den <= i_req.den;
                r_rem <= DIV_DW'(i_req.num >> i_req.nbits);
                r_sh  <= i_req.num << (DIV_CW'(DIV_NW) - i_req.nbits);
                r_q   <= '0;
            end else if (r_act) begin
                r_rem <= n_rem;
                r_sh  <= r_sh << 1;
                r_q   <= {r_q[DIV_NW-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CW'(1)) begin
                    r_act  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

`default_nettype wire

FILE: hw/rtl/lvpe_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

// Bitwise integer square root, two radicand bits per cycle.
module lvpe_sqrt
    import lvpe_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [SQ_W-1:0]  i_x,
    output logic                  o_done,
    output logic [SQ_RW-1:0]      o_root
);

    logic            r_act;
    logic            r_done;
    logic [SQ_W-1:0] r_x;
    logic [SQ_W:0]   r_r;
    logic [SQ_W-1:0] r_bit;

    logic [SQ_W:0]   trial;
    logic            ge;

    always_comb begin
        trial = r_r + {1'b0, r_bit};
        ge    = {1'b0, r_x} >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_act <= 1'b1;
                r_x   <= i_x;
                r_r   <= '0;
                r_bit <= SQ_W'(1) << (SQ_W - 2);
            end else if (r_act) begin
                if (ge) begin
                    r_x <= SQ_W'({1'b0, r_x} - trial);
                    r_r <= (r_r >> 1) + {1'b0, r_bit};
                end else begin
                    r_r <= r_r >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_bit[0]) begin
                    r_act  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[SQ_RW-1:0];

endmodule

`default_nettype wire

FILE: hw/rtl/lvpe_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module lvpe_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic        i_command,
    input  wire logic        o_strobe,
    input  wire logic [19:0] o_vp_out,
    input  wire logic [17:0] o_rho_out,
    input  wire logic [19:0] o_vs_out,
    input  wire logic        o_filled,
    input  wire logic        o_data_gap
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_strobe)
        else $error("not idle after reset");

    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && !i_command |=> !o_strobe)
        else $error("write transfer produced a result");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !(o_filled && o_data_gap))
        else $error("filled and gap both set");

    a_unfilled_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_filled |-> o_vp_out == '0 && o_rho_out == '0 && o_vs_out == '0)
        else $error("unfilled result carries values");

    a_rho_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_filled |-> o_rho_out >= 18'd29840 && o_vs_out <= o_vp_out)
        else $error("density or vs out of range");

endmodule

bind layered_velocity_profile_eval_unit lvpe_checker u_lvpe_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .i_command  (i_command),
    .o_strobe   (o_strobe),
    .o_vp_out   (o_vp_out),
    .o_rho_out  (o_rho_out),
    .o_vs_out   (o_vs_out),
    .o_filled   (o_filled),
    .o_data_gap (o_data_gap)
);

`default_nettype wire
